/* rtl/ffa_pkg.sv */
// Shared types and constants for the first-fit block allocator.
`default_nettype none
package ffa_pkg;

	localparam int FFA_HEAP_BLOCKS   = 4096;
	localparam int FFA_HEADER_BLOCKS = 1;
	localparam int FFA_MAX_EXTENTS   = 64;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOFIT    = 2'd1;
	localparam logic [1:0] ST_NOTALLOC = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// command broadcast to every cell of the free-extent chain
	typedef enum logic [2:0] {
		CC_HOLD,
		CC_START,
		CC_STEP,
		CC_SET_AT,
		CC_SET_PREV,
		CC_INSERT,
		CC_DELETE,
		CC_DEL_PREV
	} cell_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_AFIT,
		S_ASLOT,
		S_ACOMMIT,
		S_FUSED,
		S_FPOS,
		S_FCOMMIT,
		S_DONE
	} ctl_state_t;

endpackage
`default_nettype wire

/* rtl/ffa_cell.sv */
// One free-extent cell: holds one extent and a scan token, trades data with its neighbors.
`default_nettype none
module ffa_cell #(
	parameter int  AW      = 12,
	parameter int  LW      = 13,
	parameter int  RST_LEN = 0,
	parameter bit  HEAD    = 1'b0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  ffa_pkg::cell_op_t    op,
	input  wire [AW-1:0]         wr_start,
	input  wire [LW-1:0]         wr_len,
	input  wire                  left_tok,
	input  wire                  left_passed,
	input  wire [AW-1:0]         left_start,
	input  wire [LW-1:0]         left_len,
	input  wire                  right_passed,
	input  wire [AW-1:0]         right_start,
	input  wire [LW-1:0]         right_len,
	output logic                 tok,
	output logic                 passed,
	output logic [AW-1:0]        start,
	output logic [LW-1:0]        len
);
	import ffa_pkg::*;

	logic is_pos, is_prev;

	// scan stopped here / just before here
	assign is_pos  = !passed && left_passed;
	assign is_prev = passed && !right_passed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok    <= 1'b0;
			passed <= 1'b0;
			start  <= '0;
			len    <= LW'(RST_LEN);
		end else begin
			case (op)
				CC_START: begin
					tok    <= HEAD;
					passed <= 1'b0;
				end
				CC_STEP: begin
					tok    <= left_tok;
					passed <= passed | tok;
				end
				CC_SET_AT: begin
					if (is_pos) begin
						start <= wr_start;
						len   <= wr_len;
					end
				end
				CC_SET_PREV: begin
					if (is_prev) len <= wr_len;
				end
				CC_INSERT: begin
					if (is_pos) begin
						start <= wr_start;
						len   <= wr_len;
					end else if (!passed) begin
						start <= left_start;
						len   <= left_len;
					end
				end
				CC_DELETE: begin
					if (!passed) begin
						start <= right_start;
						len   <= right_len;
					end
				end
				CC_DEL_PREV: begin
					if (!passed) begin
						start <= right_start;
						len   <= right_len;
					end else if (is_prev) begin
						len <= wr_len;
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/ffa_chain.sv */
// Row of free-extent cells in address order, with the token-cell read-out.
`default_nettype none
module ffa_chain #(
	parameter int AW      = 12,
	parameter int LW      = 13,
	parameter int DEPTH   = 64,
	parameter int RST_LEN = 4096
) (
	input  wire               clk,
	input  wire               arst_n,
	input  ffa_pkg::cell_op_t op,
	input  wire [AW-1:0]      wr_start,
	input  wire [LW-1:0]      wr_len,
	output logic [AW-1:0]     tok_start,
	output logic [LW-1:0]     tok_len
);
	import ffa_pkg::*;

	logic [DEPTH-1:0]  tok_v;
	logic [DEPTH-1:0]  passed_v;
	logic [AW-1:0]     start_v [DEPTH];
	logic [LW-1:0]     len_v   [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic          l_tok, l_passed, r_passed;
		logic [AW-1:0] l_start, r_start;
		logic [LW-1:0] l_len, r_len;

		if (i == 0) begin : g_head
			assign l_tok    = 1'b0;
			assign l_passed = 1'b1;
			assign l_start  = '0;
			assign l_len    = '0;
		end else begin : g_mid
			assign l_tok    = tok_v[i-1];
			assign l_passed = passed_v[i-1];
			assign l_start  = start_v[i-1];
			assign l_len    = len_v[i-1];
		end

		if (i == DEPTH-1) begin : g_tail
			assign r_passed = 1'b0;
			assign r_start  = '0;
			assign r_len    = '0;
		end else begin : g_body
			assign r_passed = passed_v[i+1];
			assign r_start  = start_v[i+1];
			assign r_len    = len_v[i+1];
		end

		ffa_cell #(
			.AW(AW), .LW(LW),
			.RST_LEN((i == 0) ? RST_LEN : 0),
			.HEAD(i == 0)
		) u_cell (
			.clk, .arst_n, .op, .wr_start, .wr_len,
			.left_tok(l_tok), .left_passed(l_passed),
			.left_start(l_start), .left_len(l_len),
			.right_passed(r_passed), .right_start(r_start), .right_len(r_len),
			.tok(tok_v[i]), .passed(passed_v[i]),
			.start(start_v[i]), .len(len_v[i])
		);
	end

	// token is one-hot (or gone past the end): and-or select
	always_comb begin
		tok_start = '0;
		tok_len   = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tok_start = tok_start | (start_v[i] & {AW{tok_v[i]}});
			tok_len   = tok_len   | (len_v[i]   & {LW{tok_v[i]}});
		end
	end
endmodule
`default_nettype wire

/* rtl/ffa_used.sv */
// Granted-region table: start/length memory plus per-entry valid flags.
`default_nettype none
module ffa_used #(
	parameter int AW    = 12,
	parameter int LW    = 13,
	parameter int IW    = 6,
	parameter int DEPTH = 64
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire [IW-1:0]     rd_addr,
	output logic [AW-1:0]    rd_start,
	output logic [LW-1:0]    rd_len,
	input  wire              wr_en,
	input  wire [IW-1:0]     wr_addr,
	input  wire [AW-1:0]     wr_start,
	input  wire [LW-1:0]     wr_len,
	input  wire              clr_en,
	input  wire [IW-1:0]     clr_addr,
	input  wire [IW-1:0]     vq_addr,
	output logic             vq_valid
);
	logic [AW-1:0]    mem_start [DEPTH];
	logic [LW-1:0]    mem_len   [DEPTH];
	logic [DEPTH-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_start[wr_addr] <= wr_start;
			mem_len[wr_addr]   <= wr_len;
		end
		rd_start <= mem_start[rd_addr];
		rd_len   <= mem_len[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (wr_en)  valid_q[wr_addr]  <= 1'b1;
			if (clr_en) valid_q[clr_addr] <= 1'b0;
		end
	end

	assign vq_valid = valid_q[vq_addr];
endmodule
`default_nettype wire

/* rtl/first_fit_block_allocator.sv */
// Top level of the first-fit block allocator: request sequencer, free chain and used table.
// Usage:
//   Input channel (in_valid/in_stall) carries one request word: kind 0 allocates
//   size_blocks payload blocks plus the header, kind 1 releases the region whose
//   header block is free_block. Output channel (out_valid/out_stall) returns one
//   word per request: status, grant_block, grant_length.
// Timing:
//   One request at a time. Allocate walks the free chain one cell per cycle until
//   the first fitting extent, then scans used-table valid flags one per cycle for
//   a slot. Free scans the used memory one entry per cycle (registered read port),
//   then walks the chain to the insert point. The token walk through the cell row
//   and the single used-memory read port set the time that each request takes.
// Reset:
//   arst_n clears the free chain to one extent covering the whole heap and marks
//   every used entry invalid; no clearing pass is needed.
// Backpressure:
//   The result sits in an output register; a stalled receiver holds it there and
//   the next request is still taken and worked on, finishing only once the
//   register frees up.
`default_nettype none
module first_fit_block_allocator #(
	parameter int HEAP_BLOCKS   = ffa_pkg::FFA_HEAP_BLOCKS,
	parameter int HEADER_BLOCKS = ffa_pkg::FFA_HEADER_BLOCKS,
	parameter int MAX_EXTENTS   = ffa_pkg::FFA_MAX_EXTENTS
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire                                 kind,
	input  wire [$clog2(HEAP_BLOCKS + 1)-1:0]   size_blocks,
	input  wire [$clog2(HEAP_BLOCKS)-1:0]       free_block,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic [1:0]                          status,
	output logic [$clog2(HEAP_BLOCKS)-1:0]      grant_block,
	output logic [$clog2(HEAP_BLOCKS + 1)-1:0]  grant_length
);
	import ffa_pkg::*;

	localparam int AW = $clog2(HEAP_BLOCKS);
	localparam int LW = $clog2(HEAP_BLOCKS + 1);
	localparam int IW = $clog2(MAX_EXTENTS);
	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam int XW = ((LW > 14) ? LW : 14) + 1;   // room for need and sums

	ctl_state_t state_q, state_d;

	logic [CW-1:0] k_q, k_d, j_q, j_d, count_q, count_d;
	logic          cmp_v_q, cmp_v_d;
	logic [IW-1:0] rd_idx_q;
	logic [XW-1:0] need_q, need_d, blk_q, blk_d;
	logic [AW-1:0] fit_start_q, fit_start_d, prev_start_q, prev_start_d;
	logic [AW-1:0] hi_start_q, hi_start_d;
	logic [LW-1:0] fit_len_q, fit_len_d, prev_len_q, prev_len_d, hi_len_q, hi_len_d;
	logic [LW-1:0] ulen_q, ulen_d;
	logic [IW-1:0] slot_q, slot_d;
	logic [1:0]    res_st_q, res_st_d;
	logic [AW-1:0] res_blk_q, res_blk_d;
	logic [LW-1:0] res_len_q, res_len_d;
	logic          out_valid_q;
	logic [1:0]    out_st_q;
	logic [AW-1:0] out_blk_q;
	logic [LW-1:0] out_len_q;
	logic          out_load;

	// chain and used-table hookup
	cell_op_t      c_op;
	logic [AW-1:0] c_wr_start, tok_start;
	logic [LW-1:0] c_wr_len, tok_len;
	logic [AW-1:0] u_rd_start;
	logic [LW-1:0] u_rd_len;
	logic          u_wr, u_clr, vq_valid;
	logic [IW-1:0] vq_addr;

	// per-state arithmetic
	logic [XW-1:0] left_x, lo_end, hi_end;
	logic          k_lt_cnt, join_lo, join_hi, used_hit;

	ffa_chain #(
		.AW(AW), .LW(LW), .DEPTH(MAX_EXTENTS), .RST_LEN(HEAP_BLOCKS)
	) u_chain (
		.clk, .arst_n, .op(c_op), .wr_start(c_wr_start), .wr_len(c_wr_len),
		.tok_start, .tok_len
	);

	ffa_used #(
		.AW(AW), .LW(LW), .IW(IW), .DEPTH(MAX_EXTENTS)
	) u_used (
		.clk, .arst_n,
		.rd_addr(j_q[IW-1:0]), .rd_start(u_rd_start), .rd_len(u_rd_len),
		.wr_en(u_wr), .wr_addr(slot_q), .wr_start(fit_start_d), .wr_len(fit_len_d),
		.clr_en(u_clr), .clr_addr(slot_q),
		.vq_addr, .vq_valid
	);

	assign vq_addr  = (state_q == S_ASLOT) ? j_q[IW-1:0] : rd_idx_q;
	assign in_stall = (state_q != S_IDLE);
	assign out_load = !out_valid_q || !out_stall;

	assign k_lt_cnt = (k_q < count_q);
	assign left_x   = XW'(fit_len_q) - need_q;
	assign lo_end   = XW'(prev_start_q) + XW'(prev_len_q);
	assign hi_end   = blk_q + XW'(ulen_q);
	assign join_lo  = (k_q != '0) && (lo_end == blk_q);
	assign join_hi  = k_lt_cnt && (hi_end == XW'(hi_start_q));
	assign used_hit = cmp_v_q && vq_valid && (XW'(u_rd_start) == blk_q);

	always_comb begin
		state_d      = state_q;
		k_d          = k_q;
		j_d          = j_q;
		count_d      = count_q;
		cmp_v_d      = 1'b0;
		need_d       = need_q;
		blk_d        = blk_q;
		fit_start_d  = fit_start_q;
		fit_len_d    = fit_len_q;
		prev_start_d = prev_start_q;
		prev_len_d   = prev_len_q;
		hi_start_d   = hi_start_q;
		hi_len_d     = hi_len_q;
		ulen_d       = ulen_q;
		slot_d       = slot_q;
		res_st_d     = res_st_q;
		res_blk_d    = res_blk_q;
		res_len_d    = res_len_q;
		c_op         = CC_HOLD;
		c_wr_start   = '0;
		c_wr_len     = '0;
		u_wr         = 1'b0;
		u_clr        = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					need_d = XW'(size_blocks) + XW'(HEADER_BLOCKS);
					blk_d  = XW'(free_block);
					k_d    = '0;
					j_d    = '0;
					res_blk_d = '0;
					res_len_d = '0;
					if (kind == KIND_ALLOC) begin
						c_op    = CC_START;
						state_d = S_AFIT;
					end else begin
						state_d = S_FUSED;
					end
				end
			end
			S_AFIT: begin
				if (!k_lt_cnt) begin
					res_st_d = ST_NOFIT;
					state_d  = S_DONE;
				end else if (XW'(tok_len) >= need_q) begin
					fit_start_d = tok_start;
					fit_len_d   = tok_len;
					j_d         = '0;
					state_d     = S_ASLOT;
				end else begin
					c_op = CC_STEP;
					k_d  = k_q + 1'b1;
				end
			end
			S_ASLOT: begin
				if (!vq_valid) begin
					slot_d  = j_q[IW-1:0];
					state_d = S_ACOMMIT;
				end else if (j_q == CW'(MAX_EXTENTS - 1)) begin
					res_st_d = ST_FULL;
					state_d  = S_DONE;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			S_ACOMMIT: begin
				// tail split when enough is left, else take the whole extent
				if (left_x > XW'(HEADER_BLOCKS)) begin
					c_op        = CC_SET_AT;
					c_wr_start  = fit_start_q;
					c_wr_len    = LW'(left_x);
					fit_start_d = fit_start_q + AW'(left_x);
					fit_len_d   = LW'(need_q);
				end else begin
					c_op    = CC_DELETE;
					count_d = count_q - 1'b1;
				end
				u_wr      = 1'b1;
				res_st_d  = ST_OK;
				res_blk_d = fit_start_d;
				res_len_d = fit_len_d;
				state_d   = S_DONE;
			end
			S_FUSED: begin
				// issue reads in order; compare each entry in the cycle after its read
				cmp_v_d = (j_q < CW'(MAX_EXTENTS));
				if (j_q < CW'(MAX_EXTENTS)) j_d = j_q + 1'b1;
				if (used_hit) begin
					slot_d  = rd_idx_q;
					ulen_d  = u_rd_len;
					cmp_v_d = 1'b0;
					c_op    = CC_START;
					k_d     = '0;
					state_d = S_FPOS;
				end else if (cmp_v_q && rd_idx_q == IW'(MAX_EXTENTS - 1)) begin
					cmp_v_d  = 1'b0;
					res_st_d = ST_NOTALLOC;
					state_d  = S_DONE;
				end
			end
			S_FPOS: begin
				if (k_lt_cnt && (XW'(tok_start) < blk_q)) begin
					c_op         = CC_STEP;
					prev_start_d = tok_start;
					prev_len_d   = tok_len;
					k_d          = k_q + 1'b1;
				end else begin
					hi_start_d = tok_start;
					hi_len_d   = tok_len;
					state_d    = S_FCOMMIT;
				end
			end
			S_FCOMMIT: begin
				state_d  = S_DONE;
				res_st_d = ST_OK;
				if (join_lo && join_hi) begin
					c_op     = CC_DEL_PREV;
					c_wr_len = LW'(lo_end - XW'(prev_start_q) + XW'(ulen_q) + XW'(hi_len_q));
					count_d  = count_q - 1'b1;
					u_clr    = 1'b1;
				end else if (join_lo) begin
					c_op     = CC_SET_PREV;
					c_wr_len = LW'(XW'(prev_len_q) + XW'(ulen_q));
					u_clr    = 1'b1;
				end else if (join_hi) begin
					c_op       = CC_SET_AT;
					c_wr_start = AW'(blk_q);
					c_wr_len   = LW'(XW'(hi_len_q) + XW'(ulen_q));
					u_clr      = 1'b1;
				end else if (count_q == CW'(MAX_EXTENTS)) begin
					res_st_d = ST_FULL;
				end else begin
					c_op       = CC_INSERT;
					c_wr_start = AW'(blk_q);
					c_wr_len   = ulen_q;
					count_d    = count_q + 1'b1;
					u_clr      = 1'b1;
				end
			end
			S_DONE: begin
				if (out_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= CW'(1);
			k_q         <= '0;
			j_q         <= '0;
			cmp_v_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			k_q     <= k_d;
			j_q     <= j_d;
			cmp_v_q <= cmp_v_d;
			if (state_q == S_DONE && out_load) out_valid_q <= 1'b1;
			else if (!out_stall)               out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q     <= j_q[IW-1:0];
		need_q       <= need_d;
		blk_q        <= blk_d;
		fit_start_q  <= fit_start_d;
		fit_len_q    <= fit_len_d;
		prev_start_q <= prev_start_d;
		prev_len_q   <= prev_len_d;
		hi_start_q   <= hi_start_d;
		hi_len_q     <= hi_len_d;
		ulen_q       <= ulen_d;
		slot_q       <= slot_d;
		res_st_q     <= res_st_d;
		res_blk_q    <= res_blk_d;
		res_len_q    <= res_len_d;
		if (state_q == S_DONE && out_load) begin
			out_st_q  <= res_st_q;
			out_blk_q <= res_blk_q;
			out_len_q <= res_len_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_st_q;
	assign grant_block  = out_blk_q;
	assign grant_length = out_len_q;
endmodule
`default_nettype wire
